// ----- rtl/core/gprd_pkg.sv -----
// Shared constants, types and decode functions for the gamepad report remapper.
// No dependencies.
`timescale 1ns / 1ps

package gprd_pkg;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DUAL   = 2'd2;

    localparam logic [1:0] SCALE_8BIT = 2'd0;
    localparam logic [1:0] SCALE_6BIT = 2'd1;
    localparam logic [1:0] SCALE_5BIT = 2'd2;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 11;

    localparam logic [31:0] DZ_SQ   = 32'd20250000;
    localparam logic [31:0] MAX_SQ  = 32'd1043290000;
    localparam logic [23:0] DZ_M8   = 24'd1152000;
    localparam logic [14:0] SPAN    = 15'd27800;

    typedef struct packed {
        logic dz;
        logic big;
    } mag_flags_t;

    function automatic logic [7:0] scale_k(input logic [1:0] sel);
        case (sel)
            SCALE_8BIT: scale_k = 8'd127;
            SCALE_6BIT: scale_k = 8'd31;
            default:    scale_k = 8'd15;
        endcase
    endfunction

    function automatic logic [2:0] scale_shift(input logic [1:0] sel);
        case (sel)
            SCALE_8BIT: scale_shift = 3'd7;
            SCALE_6BIT: scale_shift = 3'd5;
            default:    scale_shift = 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] scale_centre(input logic [1:0] sel);
        case (sel)
            SCALE_8BIT: scale_centre = 8'd128;
            SCALE_6BIT: scale_centre = 8'd32;
            default:    scale_centre = 8'd16;
        endcase
    endfunction

    function automatic logic [7:0] scale_max(input logic [1:0] sel);
        case (sel)
            SCALE_8BIT: scale_max = 8'd255;
            SCALE_6BIT: scale_max = 8'd63;
            default:    scale_max = 8'd31;
        endcase
    endfunction

    // {up, down, right, left}
    function automatic logic [3:0] dpad_bits(input logic [7:0] code);
        case (code)
            8'd1:    dpad_bits = 4'b1000;
            8'd2:    dpad_bits = 4'b1010;
            8'd3:    dpad_bits = 4'b0010;
            8'd4:    dpad_bits = 4'b0110;
            8'd5:    dpad_bits = 4'b0100;
            8'd6:    dpad_bits = 4'b0101;
            8'd7:    dpad_bits = 4'b0001;
            8'd8:    dpad_bits = 4'b1001;
            default: dpad_bits = 4'b0000;
        endcase
    endfunction

    function automatic logic [12:0] button_word(input logic [7:0] face,
                                                input logic [7:0] menu,
                                                input logic [7:0] dpad);
        button_word = {menu[2], dpad_bits(dpad), 3'b000, menu[3],
                       face[0], face[1], face[3], face[4]};
    endfunction

endpackage

// ----- rtl/core/gprd_stick_mag.sv -----
// Stick magnitude: squares, sum, deadzone flags and pipelined integer square root.
// Depends on gprd_pkg.
`timescale 1ns / 1ps

module gprd_stick_mag
    import gprd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    output logic [23:0]        m8,
    output logic signed [16:0] ax,
    output logic signed [16:0] ay,
    output mag_flags_t         flags
);

    logic [31:0]        xsq_reg;
    logic [31:0]        ysq_reg;
    logic signed [16:0] ax1_reg;
    logic signed [16:0] ay1_reg;
    logic signed [31:0] xsq_next;
    logic signed [31:0] ysq_next;
    logic [31:0]        s2;

    logic [26:0]        rem_reg  [0:SQRT_STEPS-1];
    logic [47:0]        rad_reg  [0:SQRT_STEPS-1];
    logic [23:0]        q_reg    [0:SQRT_STEPS];
    logic signed [16:0] ax_reg   [0:SQRT_STEPS];
    logic signed [16:0] ay_reg   [0:SQRT_STEPS];
    mag_flags_t         fl_reg   [0:SQRT_STEPS];

    assign xsq_next = x * x;
    assign ysq_next = y * y;
    assign s2       = xsq_reg + ysq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xsq_reg    <= 32'(unsigned'(xsq_next));
            ysq_reg    <= 32'(unsigned'(ysq_next));
            ax1_reg    <= {x[15], x};
            ay1_reg    <= -$signed({y[15], y});
            rem_reg[0] <= '0;
            rad_reg[0] <= {s2, 16'h0000};
            q_reg[0]   <= '0;
            ax_reg[0]  <= ax1_reg;
            ay_reg[0]  <= ay1_reg;
            fl_reg[0]  <= '{dz: (s2 <= DZ_SQ), big: (s2 > MAX_SQ)};
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic [26:0] rsh;
        logic [26:0] trial;
        logic        ge;

        assign rsh   = {rem_reg[j][24:0], rad_reg[j][47:46]};
        assign trial = {1'b0, q_reg[j], 2'b01};
        assign ge    = (rsh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]  <= {q_reg[j][22:0], ge};
                ax_reg[j+1] <= ax_reg[j];
                ay_reg[j+1] <= ay_reg[j];
                fl_reg[j+1] <= fl_reg[j];
            end
        end

        if (j < SQRT_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? (rsh - trial) : rsh;
                    rad_reg[j+1] <= {rad_reg[j][45:0], 2'b00};
                end
            end
        end
    end

    assign m8    = q_reg[SQRT_STEPS];
    assign ax    = ax_reg[SQRT_STEPS];
    assign ay    = ay_reg[SQRT_STEPS];
    assign flags = fl_reg[SQRT_STEPS];

endmodule

// ----- rtl/core/gprd_axis_scale.sv -----
// One axis: deadzone rescale, numerator build and pipelined restoring division.
// Depends on gprd_pkg.
`timescale 1ns / 1ps

module gprd_axis_scale
    import gprd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [16:0] a,
    input  logic [23:0]        m8,
    input  mag_flags_t         flags,
    input  logic [1:0]         sel,
    output logic [7:0]         v
);

    // stage A
    logic [23:0]        f_reg;
    logic [38:0]        da_reg;
    logic signed [23:0] ka_reg;
    logic               dza_reg;
    logic [1:0]         sela_reg;
    logic signed [25:0] ka_next;
    logic [38:0]        dm_next;
    // stage B
    logic signed [47:0] n_reg;
    logic [47:0]        cd_reg;
    logic [38:0]        db_reg;
    logic               dzb_reg;
    logic [1:0]         selb_reg;
    logic signed [48:0] n_next;
    logic [47:0]        dext;
    // stage C and divider
    logic signed [47:0] t;
    logic [47:0]        rem_reg [0:DIV_STEPS-1];
    logic [38:0]        d_reg   [0:DIV_STEPS-1];
    logic [10:0]        q_reg   [0:DIV_STEPS];
    logic               neg_reg [0:DIV_STEPS];
    logic               dz_reg  [0:DIV_STEPS];
    logic [1:0]         sel_reg [0:DIV_STEPS];
    // output
    logic [7:0]         v_reg;
    logic [7:0]         vmax;

    assign ka_next = $signed({1'b0, scale_k(sel)}) * a;
    assign dm_next = m8 * SPAN;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg    <= flags.big ? 24'd256 : (m8 - DZ_M8);
            da_reg   <= flags.big ? {15'h0000, m8} : dm_next;
            ka_reg   <= ka_next[23:0];
            dza_reg  <= flags.dz;
            sela_reg <= sel;
        end
    end

    assign n_next = ka_reg * $signed({1'b0, f_reg});
    assign dext   = {9'h000, da_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next[47:0];
            cd_reg   <= dext << scale_shift(sela_reg);
            db_reg   <= da_reg;
            dzb_reg  <= dza_reg;
            selb_reg <= sela_reg;
        end
    end

    assign t = $signed(cd_reg) + n_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= unsigned'(t);
            d_reg[0]   <= db_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= t[47];
            dz_reg[0]  <= dzb_reg;
            sel_reg[0] <= selb_reg;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [49:0] remx;
        logic [49:0] dsh;
        logic        ge;

        assign remx = {2'b00, rem_reg[j]};
        assign dsh  = {11'h000, d_reg[j]} << SH;
        assign ge   = (remx >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]   <= {q_reg[j][9:0], ge};
                neg_reg[j+1] <= neg_reg[j];
                dz_reg[j+1]  <= dz_reg[j];
                sel_reg[j+1] <= sel_reg[j];
            end
        end

        if (j < DIV_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? 48'(remx - dsh) : rem_reg[j];
                    d_reg[j+1]   <= d_reg[j];
                end
            end
        end
    end

    assign vmax = scale_max(sel_reg[DIV_STEPS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dz_reg[DIV_STEPS])
                v_reg <= scale_centre(sel_reg[DIV_STEPS]);
            else if (neg_reg[DIV_STEPS])
                v_reg <= 8'h00;
            else if (q_reg[DIV_STEPS] > {3'b000, vmax})
                v_reg <= vmax;
            else
                v_reg <= q_reg[DIV_STEPS][7:0];
        end
    end

    assign v = v_reg;

endmodule

// ----- rtl/core/gamepad_report_remap_deadzone.sv -----
// Pipeline: input register loaded on the accepting edge, then 26 magnitude/root, 15 axis
// rescale and 1 output stage, ending in the register that drives m_tdata.
// Throughput: one report per cycle; a stall on the output freezes the whole pipeline.
// Reset (rst_n, async, active low) clears valid bits, the mode register and held sticks.
// Depends on gprd_pkg, gprd_stick_mag, gprd_axis_scale.
`timescale 1ns / 1ps

module gamepad_report_remap_deadzone
    import gprd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,     // extension_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    // face_buttons[7:0], menu_buttons[15:8], dpad_code[23:16], left_x[39:24],
    // left_y[55:40], right_x[71:56], right_y[87:72]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // core_button_word[12:0], extension_buttons[14:13], single_stick_x[22:15],
    // single_stick_y[30:23], dual_left_x[36:31], dual_left_y[42:37],
    // dual_right_x[47:43], dual_right_y[52:48], zero[55:53]
    output logic [55:0] m_tdata
);

    localparam int MAG_AT = 26;
    localparam int SCL_AT = 41;
    localparam int LAST   = 42;

    typedef struct packed {
        logic [12:0] word;
        logic [1:0]  ext;
        logic [1:0]  mode;
    } side_t;

    logic [1:0]         mode_reg;
    logic [LAST:0]      valid_reg;
    side_t              side_reg [0:SCL_AT];
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [15:0]        held_single_reg;
    logic [11:0]        held_left_reg;
    logic [9:0]         held_right_reg;
    logic [12:0]        word_out_reg;
    logic [1:0]         ext_out_reg;
    logic [15:0]        single_out_reg;
    logic [11:0]        left_out_reg;
    logic [9:0]         right_out_reg;
    logic               adv;
    side_t              side_in;
    side_t              side_end;

    logic [23:0]        lm8, rm8;
    logic signed [16:0] lax, lay, rax, ray;
    mag_flags_t         lfl, rfl;
    logic [1:0]         lsel;
    logic [7:0]         lxv, lyv, rxv, ryv;
    logic [15:0]        single_new;
    logic [11:0]        left_new;
    logic [9:0]         right_new;

    assign adv       = !valid_reg[LAST] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = valid_reg[LAST];

    assign side_in.word = button_word(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
    assign side_in.ext  = (mode_reg == MODE_SINGLE) ? {s_tdata[6], s_tdata[7]} : 2'b00;
    assign side_in.mode = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NONE;
            valid_reg       <= '0;
            held_single_reg <= '0;
            held_left_reg   <= '0;
            held_right_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            if (adv)
            begin
                valid_reg <= {valid_reg[LAST-1:0], s_tvalid};
                if (valid_reg[SCL_AT] && side_end.mode == MODE_SINGLE)
                    held_single_reg <= single_new;
                if (valid_reg[SCL_AT] && side_end.mode == MODE_DUAL)
                begin
                    held_left_reg  <= left_new;
                    held_right_reg <= right_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            lx_reg      <= s_tdata[39:24];
            ly_reg      <= s_tdata[55:40];
            rx_reg      <= s_tdata[71:56];
            ry_reg      <= s_tdata[87:72];
            for (int i = 1; i <= SCL_AT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    gprd_stick_mag u_lmag (
        .clk   (clk),
        .en    (adv),
        .x     (lx_reg),
        .y     (ly_reg),
        .m8    (lm8),
        .ax    (lax),
        .ay    (lay),
        .flags (lfl)
    );

    gprd_stick_mag u_rmag (
        .clk   (clk),
        .en    (adv),
        .x     (rx_reg),
        .y     (ry_reg),
        .m8    (rm8),
        .ax    (rax),
        .ay    (ray),
        .flags (rfl)
    );

    assign lsel = (side_reg[MAG_AT].mode == MODE_SINGLE) ? SCALE_8BIT : SCALE_6BIT;

    gprd_axis_scale u_lx (
        .clk (clk), .en (adv), .a (lax), .m8 (lm8), .flags (lfl), .sel (lsel), .v (lxv)
    );
    gprd_axis_scale u_ly (
        .clk (clk), .en (adv), .a (lay), .m8 (lm8), .flags (lfl), .sel (lsel), .v (lyv)
    );
    gprd_axis_scale u_rx (
        .clk (clk), .en (adv), .a (rax), .m8 (rm8), .flags (rfl), .sel (SCALE_5BIT),
        .v (rxv)
    );
    gprd_axis_scale u_ry (
        .clk (clk), .en (adv), .a (ray), .m8 (rm8), .flags (rfl), .sel (SCALE_5BIT),
        .v (ryv)
    );

    assign side_end   = side_reg[SCL_AT];
    assign single_new = {lyv, lxv};
    assign left_new   = {lyv[5:0], lxv[5:0]};
    assign right_new  = {ryv[4:0], rxv[4:0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_out_reg   <= side_end.word;
            ext_out_reg    <= side_end.ext;
            single_out_reg <= (side_end.mode == MODE_SINGLE) ? single_new : held_single_reg;
            left_out_reg   <= (side_end.mode == MODE_DUAL) ? left_new : held_left_reg;
            right_out_reg  <= (side_end.mode == MODE_DUAL) ? right_new : held_right_reg;
        end
    end

    assign m_tdata = {3'b000, right_out_reg[9:5], right_out_reg[4:0],
                      left_out_reg[11:6], left_out_reg[5:0],
                      single_out_reg[15:8], single_out_reg[7:0],
                      ext_out_reg, word_out_reg};

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[LAST] |-> s_tready)
        else $error("input not ready with empty output register");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    a_held_single: assert property (@(posedge clk) disable iff (!rst_n)
        held_single_reg != $past(held_single_reg) |->
            $past(adv && valid_reg[SCL_AT] && side_end.mode == MODE_SINGLE))
        else $error("single stick hold changed without a mode 1 transaction");
`endif

endmodule
